@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/nab3_pkg.sv @@
// ----------------------------------------------------------------------------
// nab3_pkg
// shared types, codes and constants of the neighbor average blur unit
// ----------------------------------------------------------------------------
package nab3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int REQ_DEPTH     = 4;
    localparam int RES_DEPTH     = 4;

    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd768;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // where a result comes from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_HOLD,
        SRC_BLUR,
        SRC_LINE
    } src_t;

    typedef struct packed {
        logic   pixel;
        src_t   src;
        logic   last;
        pixel_t px;
    } req_info_t;

    typedef struct packed {
        pixel_t px;
        logic   eof;
    } result_t;

endpackage

@@ sv/neighbor_average_blur_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// neighbor_average_blur_3x3_unit
// Takes one request per clock while in_stall is low: a pixel (RGB, raster
// order) or a drain. Each interior result channel is the sum of the eight
// neighbors, each divided by 8, with the center left out; pixels in the first
// or last row or column pass through. Results trail the input by one row plus
// one pixel, and after the last pixel of a frame one drain request releases
// each pending result, the final one flagged end_of_frame. Throughput is one
// request per clock while in_stall is low, set by the single read and write
// of each line store per request and the window shift per pixel. A result
// passes the request queue, the s1 registers and the result queue. Two line
// stores of MAX_WIDTH x 24 bits hold the rows above. Write frame_width and
// frame_height only after reset or after end_of_frame, while the unit is idle.
// ----------------------------------------------------------------------------
module neighbor_average_blur_3x3_unit #(
    parameter int MAX_WIDTH = nab3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [7:0]                            in_red,
    input  logic [7:0]                            in_green,
    input  logic [7:0]                            in_blue,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            out_red,
    output logic [7:0]                            out_green,
    output logic [7:0]                            out_blue,
    output logic                                  end_of_frame,
    input  logic                                  cfg_write,
    input  logic [nab3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [nab3_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int REQ_W = $bits(nab3_pkg::req_info_t) + COL_W;
    localparam int CNT_W = $clog2(nab3_pkg::REQ_DEPTH + 1);

    logic                push;
    nab3_pkg::req_info_t push_info;
    logic [COL_W-1:0]    push_addr;
    logic                req_full;
    logic                req_empty;
    logic                req_pop;
    logic [CNT_W-1:0]    req_count;
    logic [REQ_W-1:0]    req_pop_data;
    nab3_pkg::req_info_t pop_info;
    logic [COL_W-1:0]    pop_addr;
    nab3_pkg::result_t   result;

    nab3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_full  (req_full),
        .req_push  (push),
        .req_info  (push_info),
        .req_addr  (push_addr)
    );

    nab3_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (nab3_pkg::REQ_DEPTH)
    ) u_req_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_info, push_addr}),
        .pop       (req_pop),
        .pop_data  (req_pop_data),
        .count     (req_count),
        .full      (req_full),
        .empty     (req_empty)
    );

    assign pop_info = nab3_pkg::req_info_t'(req_pop_data[REQ_W-1:COL_W]);
    assign pop_addr = req_pop_data[COL_W-1:0];

    nab3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_empty (req_empty),
        .req_info  (pop_info),
        .req_addr  (pop_addr),
        .req_pop   (req_pop),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .result    (result)
    );

    assign out_red      = result.px.red;
    assign out_green    = result.px.green;
    assign out_blue     = result.px.blue;
    assign end_of_frame = result.eof;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_req_count, (req_count == '0) == req_empty, "request queue count and empty disagree")

endmodule

@@ sv/nab3_fifo.sv @@
// ----------------------------------------------------------------------------
// nab3_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nab3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [WIDTH-1:0]                 push_data,
    input  logic                             pop,
    output logic [WIDTH-1:0]                 pop_data,
    output logic [$clog2(DEPTH+1)-1:0]       count,
    output logic                             full,
    output logic                             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = store_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, push, !full, "push into full queue")
    `ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

@@ sv/nab3_front.sv @@
// ----------------------------------------------------------------------------
// nab3_front
// accepts requests, tracks frame position and classifies each request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nab3_front #(
    parameter int MAX_WIDTH = nab3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [7:0]                            in_red,
    input  logic [7:0]                            in_green,
    input  logic [7:0]                            in_blue,
    input  logic                                  cfg_write,
    input  logic [nab3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [nab3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  req_full,
    output logic                                  req_push,
    output nab3_pkg::req_info_t                   req_info,
    output logic [$clog2(MAX_WIDTH)-1:0]          req_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = nab3_pkg::WIDTH_BITS;
    localparam int ROW_W = nab3_pkg::HEIGHT_BITS;
    localparam int SUM_W = ((COL_W > W_W) ? COL_W : W_W) + 1;

    logic [W_W-1:0]   width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [COL_W-1:0] icol_reg;
    logic [COL_W-1:0] icol_next;
    logic [ROW_W-1:0] irow_reg;
    logic [ROW_W-1:0] irow_next;
    logic [COL_W-1:0] ocol_reg;
    logic [COL_W-1:0] ocol_next;
    logic [ROW_W-1:0] orow_reg;
    logic [ROW_W-1:0] orow_next;

    logic [W_W-1:0]   w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [SUM_W-1:0] w_ext;
    logic [SUM_W-1:0] icol_ext;
    logic [SUM_W-1:0] icol_p1;
    logic [SUM_W-1:0] ocol_p1;
    logic [ROW_W:0]   orow_p1;
    logic [ROW_W:0]   er_p1;
    logic             complete;
    logic             accept;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] er;
    logic             ec_last;
    logic [COL_W-1:0] ec_p1;
    logic             border;

    assign in_stall = req_full;
    assign accept   = in_valid && !req_full;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign w_ext    = SUM_W'(w_eff);
    assign icol_ext = SUM_W'(icol_reg);
    assign icol_p1  = icol_ext + SUM_W'(1);
    assign ocol_p1  = SUM_W'(ocol_reg) + SUM_W'(1);
    assign orow_p1  = {1'b0, orow_reg} + (ROW_W+1)'(1);
    assign er_p1    = {1'b0, er} + (ROW_W+1)'(1);
    assign complete = (irow_reg >= h_eff);
    assign last     = emit && (er_p1 >= {1'b0, h_eff}) && ec_last;

    always_comb
    begin
        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        req_push  = 1'b0;
        req_addr  = '0;
        req_info  = '{pixel: 1'b0, src: nab3_pkg::SRC_NONE, last: 1'b0, px: '0};
        emit      = 1'b0;
        er        = '0;
        ec_last   = 1'b0;
        ec_p1     = '0;
        border    = 1'b0;

        if (accept)
        begin
            if (operation == nab3_pkg::OP_DRAIN)
            begin
                if (complete)
                begin
                    req_push     = 1'b1;
                    req_addr     = ocol_reg;
                    req_info.src = (orow_p1 >= {1'b0, h_eff}) ? nab3_pkg::SRC_LINE
                                                              : nab3_pkg::SRC_HOLD;
                    emit         = 1'b1;
                    er           = orow_reg;
                    ec_last      = (ocol_p1 >= w_ext);
                    ec_p1        = ocol_p1[COL_W-1:0];
                end
            end
            else if (!complete)
            begin
                req_push       = 1'b1;
                req_addr       = icol_reg;
                req_info.pixel = 1'b1;
                req_info.px    = '{red: in_red, green: in_green, blue: in_blue};
                if (icol_p1 >= w_ext)
                begin
                    icol_next = '0;
                    irow_next = irow_reg + ROW_W'(1);
                end
                else
                begin
                    icol_next = icol_p1[COL_W-1:0];
                end

                if (icol_reg != '0 && irow_reg != '0)
                begin
                    // window centered one row up and one column left
                    emit         = 1'b1;
                    er           = irow_reg - ROW_W'(1);
                    ec_last      = (icol_ext >= w_ext);
                    ec_p1        = icol_reg;
                    border       = (irow_reg == ROW_W'(1)) || (icol_reg == COL_W'(1)) ||
                                   ec_last;
                    req_info.src = border ? nab3_pkg::SRC_HOLD : nab3_pkg::SRC_BLUR;
                end
                else if (icol_reg == '0 && irow_reg >= ROW_W'(2))
                begin
                    // right edge pixel of the row two up
                    emit         = 1'b1;
                    er           = irow_reg - ROW_W'(2);
                    ec_last      = 1'b1;
                    req_info.src = nab3_pkg::SRC_HOLD;
                end
            end

            if (emit)
            begin
                req_info.last = last;
                if (last)
                begin
                    icol_next = '0;
                    irow_next = '0;
                    ocol_next = '0;
                    orow_next = '0;
                end
                else if (ec_last)
                begin
                    orow_next = er_p1[ROW_W-1:0];
                    ocol_next = '0;
                end
                else
                begin
                    orow_next = er;
                    ocol_next = ec_p1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nab3_pkg::WIDTH_RESET;
            height_reg <= nab3_pkg::HEIGHT_RESET;
            icol_reg   <= '0;
            irow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    nab3_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[W_W-1:0];
                    nab3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                endcase
            end
        end
    end

    `ASSERT_IMPLY(a_last_on_drain, req_push && req_info.last, !req_info.pixel, "frame end on pixel request")
    `ASSERT_IMPLY(a_drain_when_done, req_push && !req_info.pixel, complete, "drain queued before frame is in")

endmodule

@@ sv/nab3_back.sv @@
// ----------------------------------------------------------------------------
// nab3_back
// line stores, 3x3 window, neighbor sum and result queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nab3_back #(
    parameter int MAX_WIDTH = nab3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_empty,
    input  nab3_pkg::req_info_t           req_info,
    input  logic [$clog2(MAX_WIDTH)-1:0]  req_addr,
    output logic                          req_pop,
    output logic                          res_valid,
    input  logic                          res_stall,
    output nab3_pkg::result_t             result
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RES_W = $bits(nab3_pkg::result_t);
    localparam int CNT_W = $clog2(nab3_pkg::RES_DEPTH + 1);

    logic [23:0]         upper_line_mem  [MAX_WIDTH];
    logic [23:0]         middle_line_mem [MAX_WIDTH];

    logic                s1_valid_reg;
    nab3_pkg::req_info_t s1_info_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    nab3_pkg::pixel_t    upper_rd_reg;
    nab3_pkg::pixel_t    middle_rd_reg;
    logic                byp_reg;
    nab3_pkg::pixel_t    byp_upper_reg;
    nab3_pkg::pixel_t    byp_middle_reg;
    nab3_pkg::pixel_t    win_reg [3][3];

    nab3_pkg::pixel_t    up_eff;
    nab3_pkg::pixel_t    mid_eff;
    nab3_pkg::pixel_t    col [3];
    nab3_pkg::pixel_t    nb [8];
    nab3_pkg::pixel_t    blur;
    nab3_pkg::pixel_t    res_px;
    nab3_pkg::result_t   res_in;
    logic                s1_write;
    logic                s1_emit;
    logic                room;
    logic                res_pop;
    logic                res_full;
    logic                res_empty;
    logic [CNT_W-1:0]    res_count;
    logic [RES_W-1:0]    res_data;

    assign s1_write = s1_valid_reg && s1_info_reg.pixel;
    assign s1_emit  = s1_valid_reg && (s1_info_reg.src != nab3_pkg::SRC_NONE);
    assign room     = ((CNT_W+1)'(res_count) + (CNT_W+1)'(s1_emit)) <
                      (CNT_W+1)'(nab3_pkg::RES_DEPTH);
    assign req_pop  = !req_empty && room;

    // a pixel one request back may have written the address just read
    assign up_eff  = byp_reg ? byp_upper_reg  : upper_rd_reg;
    assign mid_eff = byp_reg ? byp_middle_reg : middle_rd_reg;

    assign col[0] = up_eff;
    assign col[1] = mid_eff;
    assign col[2] = s1_info_reg.px;

    always_comb
    begin
        nb[0] = win_reg[0][1];
        nb[1] = win_reg[0][2];
        nb[2] = up_eff;
        nb[3] = win_reg[1][1];
        nb[4] = mid_eff;
        nb[5] = win_reg[2][1];
        nb[6] = win_reg[2][2];
        nb[7] = s1_info_reg.px;
        blur  = '0;
        for (int i = 0; i < 8; i++)
        begin
            blur.red   = blur.red   + 8'(nb[i].red[7:3]);
            blur.green = blur.green + 8'(nb[i].green[7:3]);
            blur.blue  = blur.blue  + 8'(nb[i].blue[7:3]);
        end
    end

    always_comb
    begin
        case (s1_info_reg.src)
            nab3_pkg::SRC_BLUR: res_px = blur;
            nab3_pkg::SRC_LINE: res_px = mid_eff;
            default:            res_px = win_reg[1][2];
        endcase
    end

    assign res_in = '{px: res_px, eof: s1_info_reg.last};

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            upper_rd_reg   <= upper_line_mem[req_addr];
            middle_rd_reg  <= middle_line_mem[req_addr];
            byp_upper_reg  <= mid_eff;
            byp_middle_reg <= s1_info_reg.px;
            s1_info_reg    <= req_info;
            s1_addr_reg    <= req_addr;
        end
        if (s1_write)
        begin
            upper_line_mem[s1_addr_reg]  <= mid_eff;
            middle_line_mem[s1_addr_reg] <= s1_info_reg.px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            s1_valid_reg <= req_pop;
            if (req_pop)
            begin
                byp_reg <= s1_write && (s1_addr_reg == req_addr);
            end
            if (s1_write)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                    win_reg[r][2] <= col[r];
                end
            end
        end
    end

    nab3_fifo #(
        .WIDTH (RES_W),
        .DEPTH (nab3_pkg::RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_emit),
        .push_data (res_in),
        .pop       (res_pop),
        .pop_data  (res_data),
        .count     (res_count),
        .full      (res_full),
        .empty     (res_empty)
    );

    assign res_valid = !res_empty;
    assign res_pop   = res_valid && !res_stall;
    assign result    = nab3_pkg::result_t'(res_data);

    `ASSERT_IMPLY(a_line_src_drain, s1_write, s1_info_reg.src != nab3_pkg::SRC_LINE, "pixel request reads line store result")
    `ASSERT_IMPLY(a_res_room, s1_emit, !res_full, "result arrives with no room")

endmodule

@@ bench/neighbor_average_blur_3x3_unit_test.sv @@
// ----------------------------------------------------------------------------
// neighbor_average_blur_3x3_unit_test
// Streams RGB frames of many sizes through the blur unit, from 1x1 up to forty
// pixels wide and forty rows tall, with early drains and pixels sent past the
// end of a frame mixed in. A scoreboard class tracks the line stores, window
// and counters of the unit and compares every result pixel and end_of_frame
// flag in order. Both handshakes idle at random, including a long output
// hold-off and a pause of the pixel stream until all results are out.
// ----------------------------------------------------------------------------
module neighbor_average_blur_3x3_unit_test;

    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int          CFG_W           = nab3_pkg::CFG_DATA_BITS;

    class blur_scoreboard;
        int unsigned       width_reg;
        int unsigned       height_reg;
        nab3_pkg::pixel_t  upper_row [nab3_pkg::MAX_WIDTH_DEF];
        nab3_pkg::pixel_t  middle_row [nab3_pkg::MAX_WIDTH_DEF];
        nab3_pkg::pixel_t  win [3][3];
        int unsigned       in_col;
        int unsigned       in_row;
        int unsigned       out_col;
        int unsigned       out_row;
        nab3_pkg::result_t blurred_due [$];
        int unsigned       errors;

        function new();
            width_reg  = nab3_pkg::WIDTH_RESET;
            height_reg = nab3_pkg::HEIGHT_RESET;
            for (int i = 0; i < nab3_pkg::MAX_WIDTH_DEF; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            clear_counters();
            errors = 0;
        endfunction

        function void clear_counters();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void set_register(logic [nab3_pkg::CFG_INDEX_BITS-1:0] idx,
                                   logic [nab3_pkg::CFG_DATA_BITS-1:0] value);
            if (idx == nab3_pkg::REG_FRAME_WIDTH)
                width_reg = value[nab3_pkg::WIDTH_BITS-1:0];
            else if (idx == nab3_pkg::REG_FRAME_HEIGHT)
                height_reg = value[nab3_pkg::HEIGHT_BITS-1:0];
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > nab3_pkg::MAX_WIDTH_DEF)
                return nab3_pkg::MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned line_slot(int unsigned c);
            return (c < nab3_pkg::MAX_WIDTH_DEF) ? c : nab3_pkg::MAX_WIDTH_DEF - 1;
        endfunction

        function bit frame_complete();
            return in_row >= eff_height();
        endfunction

        function int unsigned due_count();
            return blurred_due.size();
        endfunction

        function nab3_pkg::pixel_t blur_center();
            int unsigned      r_sum;
            int unsigned      g_sum;
            int unsigned      b_sum;
            nab3_pkg::pixel_t px;
            r_sum = 0;
            g_sum = 0;
            b_sum = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (r != 1 || c != 1)
                    begin
                        r_sum += win[r][c].red >> 3;
                        g_sum += win[r][c].green >> 3;
                        b_sum += win[r][c].blue >> 3;
                    end
            px.red   = 8'(r_sum);
            px.green = 8'(g_sum);
            px.blue  = 8'(b_sum);
            return px;
        endfunction

        function void emit(int unsigned er, int unsigned ec, nab3_pkg::pixel_t px);
            nab3_pkg::result_t res;
            bit                last;
            last    = (er + 1 >= eff_height()) && (ec + 1 >= eff_width());
            res.px  = px;
            res.eof = last;
            blurred_due.push_back(res);
            if (last)
                clear_counters();
            else if (ec + 1 >= eff_width())
            begin
                out_row = er + 1;
                out_col = 0;
            end
            else
            begin
                out_row = er;
                out_col = ec + 1;
            end
        endfunction

        function void take_request(logic op, nab3_pkg::pixel_t px);
            int unsigned      w;
            int unsigned      h;
            int unsigned      ic;
            int unsigned      ir;
            int unsigned      li;
            nab3_pkg::pixel_t right_mid;
            nab3_pkg::pixel_t col [3];
            bit               border;
            w  = eff_width();
            h  = eff_height();
            if (op == nab3_pkg::OP_DRAIN)
            begin
                if (!frame_complete())
                    return;
                if (out_row + 1 >= h)
                    emit(out_row, out_col, middle_row[line_slot(out_col)]);
                else
                    emit(out_row, out_col, win[1][2]);
                return;
            end
            if (frame_complete())
                return;
            ic        = in_col;
            ir        = in_row;
            li        = line_slot(ic);
            right_mid = win[1][2];
            col[0]    = upper_row[li];
            col[1]    = middle_row[li];
            col[2]    = px;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
                win[r][2] = col[r];
            end
            upper_row[li]  = middle_row[li];
            middle_row[li] = px;
            if (ic + 1 >= w)
            begin
                in_col = 0;
                in_row = ir + 1;
            end
            else
                in_col = ic + 1;
            if (ic >= 1 && ir >= 1)
            begin
                border = (ir == 1) || (ic == 1) || (ic >= w) || (ir >= h);
                emit(ir - 1, ic - 1, border ? win[1][1] : blur_center());
            end
            else if (ic == 0 && ir >= 2)
                emit(ir - 2, w - 1, right_mid);
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            errors++;
            $display("%0t  %s expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void check_pixel(nab3_pkg::result_t got);
            nab3_pkg::result_t want;
            if (blurred_due.size() == 0)
            begin
                errors++;
                $display("%0t  result with nothing expected: actual %h", $time, got);
                return;
            end
            want = blurred_due.pop_front();
            if (got.px.red !== want.px.red)
                report("out_red", want.px.red, got.px.red);
            if (got.px.green !== want.px.green)
                report("out_green", want.px.green, got.px.green);
            if (got.px.blue !== want.px.blue)
                report("out_blue", want.px.blue, got.px.blue);
            if (got.eof !== want.eof)
                report("end_of_frame", want.eof, got.eof);
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                operation;
    logic [7:0]                          in_red;
    logic [7:0]                          in_green;
    logic [7:0]                          in_blue;
    logic                                out_valid;
    logic                                out_stall;
    logic [7:0]                          out_red;
    logic [7:0]                          out_green;
    logic [7:0]                          out_blue;
    logic                                end_of_frame;
    logic                                cfg_write;
    logic [nab3_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [nab3_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    blur_scoreboard sb;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    bit             hold_off_request = 1'b0;
    int unsigned    stream_items = 0;

    neighbor_average_blur_3x3_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_frame (end_of_frame),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // output side: random stall, long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel({out_red, out_green, out_blue, end_of_frame});
    end

    function automatic nab3_pkg::pixel_t random_pixel();
        random_pixel = 24'($urandom);
    endfunction

    task automatic send_request(input logic op, input nab3_pkg::pixel_t px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        in_red    <= px.red;
        in_green  <= px.green;
        in_blue   <= px.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_request(op, px);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_count() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [nab3_pkg::CFG_DATA_BITS-1:0] width_value,
                             input logic [nab3_pkg::CFG_DATA_BITS-1:0] height_value);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= nab3_pkg::REG_FRAME_WIDTH;
        cfg_data  <= width_value;
        @(posedge clk);
        cfg_index <= nab3_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= height_value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(nab3_pkg::REG_FRAME_WIDTH, width_value);
        sb.set_register(nab3_pkg::REG_FRAME_HEIGHT, height_value);
    endtask

    task automatic run_frame(input int unsigned noise_pct, input int unsigned hold_at,
                             input int unsigned pause_at);
        int unsigned n;
        n = 0;
        while (!sb.frame_complete())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(nab3_pkg::OP_DRAIN, random_pixel());
            n++;
            if (n == hold_at)
                hold_off_request = 1'b1;
            if (n == pause_at)
                wait_for_results();
            send_request(nab3_pkg::OP_PIXEL, random_pixel());
            stream_items++;
        end
        while (sb.frame_complete())
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(nab3_pkg::OP_PIXEL, random_pixel());
            send_request(nab3_pkg::OP_DRAIN, random_pixel());
            stream_items++;
        end
        if ($urandom_range(0, 99) < noise_pct)
            send_request(nab3_pkg::OP_DRAIN, random_pixel());
    endtask

    task automatic run_random_frames(input int unsigned budget);
        int unsigned                        start;
        int unsigned                        hold_at;
        int unsigned                        pause_at;
        logic [nab3_pkg::CFG_DATA_BITS-1:0] width_value;
        logic [nab3_pkg::CFG_DATA_BITS-1:0] height_value;
        start = stream_items;
        while (stream_items - start < budget)
        begin
            if (stream_items == start || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       width_value = '0;
                    1:       width_value = CFG_W'($urandom_range(11, 40));
                    default: width_value = CFG_W'($urandom_range(1, 10));
                endcase
                case ($urandom_range(0, 9))
                    0:       height_value = '0;
                    1:       height_value = CFG_W'($urandom_range(9, 16));
                    default: height_value = CFG_W'($urandom_range(1, 8));
                endcase
                configure(width_value, height_value);
            end
            hold_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 0;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 0;
            run_frame(5, hold_at, pause_at);
        end
    endtask

    initial
    begin
        int unsigned k;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = nab3_pkg::OP_PIXEL;
        in_red    = '0;
        in_green  = '0;
        in_blue   = '0;
        cfg_write = 1'b0;
        cfg_index = nab3_pkg::REG_FRAME_WIDTH;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // 3x3 frame, bright ring around a dark center gives the largest blur
                configure(16'd3, 16'd3);
                send_request(nab3_pkg::OP_DRAIN, '0);
                for (k = 0; k < 9; k++)
                    send_request(nab3_pkg::OP_PIXEL, (k == 4) ? 24'h000000 : 24'hFFFFFF);
                send_request(nab3_pkg::OP_PIXEL, 24'h5AC3_0F);
                while (sb.frame_complete())
                    send_request(nab3_pkg::OP_DRAIN, '1);
                send_request(nab3_pkg::OP_DRAIN, '0);
                // zero width and height act as a single pixel frame
                configure(16'd0, 16'd0);
                send_request(nab3_pkg::OP_PIXEL, 24'hA53C_F0);
                send_request(nab3_pkg::OP_DRAIN, '0);
            end

            run_random_frames(320);

            case (phase)
                0:
                begin
                    configure(16'd40, 16'd3);
                    run_frame(0, 30, 80);
                end
                1:
                begin
                    configure(16'd12, 16'd1);
                    run_frame(3, 0, 0);
                end
                default:
                begin
                    configure(16'd1, 16'd40);
                    run_frame(0, 10, 25);
                end
            endcase
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due_count() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
